// ===== sv/fmc_pkg.sv =====
// Shared types, codes and constants of the file magic classifier.
package fmc_pkg;

	localparam int unsigned PREFIX_BYTES = 128;

	localparam int unsigned HDR_BYTES  = 6;
	localparam int unsigned MACH_POS_LO = 18;
	localparam int unsigned MACH_POS_HI = 19;
	localparam int unsigned MACH_MIN_BYTES = 20;

	typedef logic [7:0] byte_t;

	typedef enum logic [3:0] {
		KIND_EMPTY        = 4'd0,
		KIND_DATA         = 4'd1,
		KIND_WRAP_X64     = 4'd2,
		KIND_WRAP_M68K    = 4'd3,
		KIND_WRAP_NATIVE  = 4'd4,
		KIND_WRAP_UNKNOWN = 4'd5,
		KIND_WRAP_SHORT   = 4'd6,
		KIND_ELF          = 4'd7,
		KIND_HUNK         = 4'd8,
		KIND_ASCII        = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		CLASS_64      = 2'd0,
		CLASS_32      = 2'd1,
		CLASS_UNKNOWN = 2'd2
	} elf_class_t;

	typedef enum logic [1:0] {
		MACH_X86_64  = 2'd0,
		MACH_M68K    = 2'd1,
		MACH_UNKNOWN = 2'd2,
		MACH_NONE    = 2'd3
	} elf_mach_t;

	localparam byte_t ELF_MAG0 = 8'h7F;
	localparam byte_t ELF_MAG1 = 8'h45; // E
	localparam byte_t ELF_MAG2 = 8'h4C; // L
	localparam byte_t ELF_MAG3 = 8'h46; // F

	localparam byte_t WRAP_MAG0 = 8'h55; // U
	localparam byte_t WRAP_MAG1 = 8'h41; // A
	localparam byte_t WRAP_MAG2 = 8'h4F; // O
	localparam byte_t WRAP_MAG3 = 8'h53; // S

	localparam logic [31:0] HUNK_MAGIC = 32'h0000_03F3;

	localparam logic [15:0] WRAP_TYPE_X64    = 16'h0003;
	localparam logic [15:0] WRAP_TYPE_M68K   = 16'h0002;
	localparam logic [15:0] WRAP_TYPE_NATIVE = 16'h0001;

	localparam byte_t ELFCLASS32 = 8'd1;
	localparam byte_t ELFCLASS64 = 8'd2;

	localparam logic [15:0] MACHINE_ID_X64  = 16'd62;
	localparam logic [15:0] MACHINE_ID_M68K = 16'd4;

	localparam int unsigned TEXT_NUM = 10;
	localparam int unsigned TEXT_DEN = 9;

	typedef struct packed {
		kind_t      kind;
		elf_class_t elf_class;
		elf_mach_t  elf_machine;
	} result_t;

	function automatic logic is_text(input byte_t c);
		is_text = (c >= 8'h20 && c <= 8'h7E) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

// ===== sv/fmc_byte_if.sv =====
// Byte stream channel: one file byte per item with presence and last marks.
interface fmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last;

	modport source (output valid, output data_byte, output byte_present, output last,
		input ready);
	modport sink (input valid, input data_byte, input byte_present, input last,
		output ready);
endinterface

// ===== sv/fmc_result_if.sv =====
// Result channel: one classification per file.
interface fmc_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] kind;
	logic [1:0] elf_class;
	logic [1:0] elf_machine;

	modport source (output valid, output kind, output elf_class, output elf_machine,
		input ready);
	modport sink (input valid, input kind, input elf_class, input elf_machine,
		output ready);
endinterface

// ===== sv/file_magic_classifier.sv =====
// Top level of the file magic classifier: byte intake, per-file state and result register.
//
// Takes one byte of a file per cycle and returns one classification on the item
// marked last. Every cycle a new item may be accepted; a result is offered once its
// last item has moved from the input register into the result register, and a stalled
// result holds back intake only once both registers are full. Only the first
// PREFIX_BYTES bytes of each file are examined; items with byte_present low carry no
// byte but may still close the file. All per-file state clears after each last item.
module file_magic_classifier #(
	parameter int unsigned PREFIX_BYTES = fmc_pkg::PREFIX_BYTES
) (
	input logic           clk,
	input logic           arst_n,
	fmc_byte_if.sink      byte_ch,
	fmc_result_if.source  result_ch
);
	localparam int unsigned CNT_W = $clog2(PREFIX_BYTES + 1);

	logic             valid_s1;
	fmc_pkg::byte_t   byte_s1;
	logic             present_s1;
	logic             last_s1;
	logic             advance_s1;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] text_q;
	fmc_pkg::byte_t   hdr_q [fmc_pkg::HDR_BYTES];
	fmc_pkg::byte_t   mach_lo_q;
	fmc_pkg::byte_t   mach_hi_q;

	logic             take_byte;
	logic [CNT_W-1:0] count_nxt;
	logic [CNT_W-1:0] text_nxt;
	fmc_pkg::byte_t   hdr_nxt [fmc_pkg::HDR_BYTES];
	fmc_pkg::byte_t   mach_lo_nxt;
	fmc_pkg::byte_t   mach_hi_nxt;

	fmc_pkg::result_t result_comb;
	fmc_pkg::result_t result_q;
	logic             out_valid_q;

	assign advance_s1    = !out_valid_q || result_ch.ready;
	assign byte_ch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1    <= byte_ch.data_byte;
			present_s1 <= byte_ch.byte_present;
			last_s1    <= byte_ch.last;
		end
	end

	assign take_byte = valid_s1 && present_s1 && count_q < CNT_W'(PREFIX_BYTES);

	always_comb begin
		count_nxt   = count_q;
		text_nxt    = text_q;
		mach_lo_nxt = mach_lo_q;
		mach_hi_nxt = mach_hi_q;
		for (int i = 0; i < fmc_pkg::HDR_BYTES; i++) begin
			hdr_nxt[i] = hdr_q[i];
			if (take_byte && count_q == CNT_W'(i)) begin
				hdr_nxt[i] = byte_s1;
			end
		end
		if (take_byte) begin
			count_nxt = count_q + CNT_W'(1);
			if (fmc_pkg::is_text(byte_s1)) begin
				text_nxt = text_q + CNT_W'(1);
			end
			if (count_q == CNT_W'(fmc_pkg::MACH_POS_LO)) begin
				mach_lo_nxt = byte_s1;
			end
			if (count_q == CNT_W'(fmc_pkg::MACH_POS_HI)) begin
				mach_hi_nxt = byte_s1;
			end
		end
	end

	fmc_decide #(
		.PREFIX_BYTES (PREFIX_BYTES)
	) u_decide (
		.byte_count      (count_nxt),
		.printable_count (text_nxt),
		.hdr             (hdr_nxt),
		.mach_lo         (mach_lo_nxt),
		.mach_hi         (mach_hi_nxt),
		.result          (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			text_q    <= '0;
			mach_lo_q <= '0;
			mach_hi_q <= '0;
			for (int i = 0; i < fmc_pkg::HDR_BYTES; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (valid_s1 && advance_s1) begin
			if (last_s1) begin
				count_q   <= '0;
				text_q    <= '0;
				mach_lo_q <= '0;
				mach_hi_q <= '0;
				for (int i = 0; i < fmc_pkg::HDR_BYTES; i++) begin
					hdr_q[i] <= '0;
				end
			end else begin
				count_q   <= count_nxt;
				text_q    <= text_nxt;
				mach_lo_q <= mach_lo_nxt;
				mach_hi_q <= mach_hi_nxt;
				for (int i = 0; i < fmc_pkg::HDR_BYTES; i++) begin
					hdr_q[i] <= hdr_nxt[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1 && last_s1) begin
			result_q <= result_comb;
		end
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.kind        = result_q.kind;
	assign result_ch.elf_class   = result_q.elf_class;
	assign result_ch.elf_machine = result_q.elf_machine;

endmodule

// ===== sv/fmc_decide.sv =====
// Classification of one file from its collected header bytes and counts.
module fmc_decide #(
	parameter int unsigned PREFIX_BYTES = fmc_pkg::PREFIX_BYTES
) (
	input  logic [$clog2(PREFIX_BYTES+1)-1:0] byte_count,
	input  logic [$clog2(PREFIX_BYTES+1)-1:0] printable_count,
	input  fmc_pkg::byte_t                    hdr [fmc_pkg::HDR_BYTES],
	input  fmc_pkg::byte_t                    mach_lo,
	input  fmc_pkg::byte_t                    mach_hi,
	output fmc_pkg::result_t                  result
);
	localparam int unsigned CNT_W = $clog2(PREFIX_BYTES + 1);
	localparam int unsigned PROD_W = CNT_W + 4;

	logic              is_wrap;
	logic              is_elf;
	logic              is_hunk;
	logic              mostly_text;
	logic [15:0]       wrap_type;
	logic [15:0]       machine;
	fmc_pkg::byte_t    cls_byte;
	logic [PROD_W-1:0] text_scaled;
	logic [PROD_W-1:0] total_scaled;

	assign is_wrap = hdr[0] == fmc_pkg::WRAP_MAG0 && hdr[1] == fmc_pkg::WRAP_MAG1 &&
		hdr[2] == fmc_pkg::WRAP_MAG2 && hdr[3] == fmc_pkg::WRAP_MAG3;
	assign is_elf = hdr[0] == fmc_pkg::ELF_MAG0 && hdr[1] == fmc_pkg::ELF_MAG1 &&
		hdr[2] == fmc_pkg::ELF_MAG2 && hdr[3] == fmc_pkg::ELF_MAG3;
	assign is_hunk = {hdr[0], hdr[1], hdr[2], hdr[3]} == fmc_pkg::HUNK_MAGIC;

	assign text_scaled  = PROD_W'(printable_count) * PROD_W'(fmc_pkg::TEXT_NUM);
	assign total_scaled = PROD_W'(byte_count) * PROD_W'(fmc_pkg::TEXT_DEN);
	assign mostly_text  = text_scaled >= total_scaled;

	assign wrap_type = {hdr[4], hdr[5]};
	assign cls_byte  = (byte_count >= CNT_W'(5)) ? hdr[4] : 8'd0;

	always_comb begin
		machine = 16'd0;
		if ((cls_byte == fmc_pkg::ELFCLASS32 || cls_byte == fmc_pkg::ELFCLASS64) &&
			byte_count >= CNT_W'(fmc_pkg::MACH_MIN_BYTES)) begin
			machine = {mach_hi, mach_lo};
		end
	end

	always_comb begin
		result.kind        = fmc_pkg::KIND_DATA;
		result.elf_class   = fmc_pkg::CLASS_UNKNOWN;
		result.elf_machine = fmc_pkg::MACH_NONE;
		priority if (byte_count < CNT_W'(4)) begin
			result.kind = (byte_count == '0) ? fmc_pkg::KIND_EMPTY : fmc_pkg::KIND_DATA;
		end else if (is_wrap) begin
			priority if (byte_count < CNT_W'(fmc_pkg::HDR_BYTES)) begin
				result.kind = fmc_pkg::KIND_WRAP_SHORT;
			end else if (wrap_type == fmc_pkg::WRAP_TYPE_X64) begin
				result.kind = fmc_pkg::KIND_WRAP_X64;
			end else if (wrap_type == fmc_pkg::WRAP_TYPE_M68K) begin
				result.kind = fmc_pkg::KIND_WRAP_M68K;
			end else if (wrap_type == fmc_pkg::WRAP_TYPE_NATIVE) begin
				result.kind = fmc_pkg::KIND_WRAP_NATIVE;
			end else begin
				result.kind = fmc_pkg::KIND_WRAP_UNKNOWN;
			end
		end else if (is_elf) begin
			result.kind = fmc_pkg::KIND_ELF;
			priority if (cls_byte == fmc_pkg::ELFCLASS64) begin
				result.elf_class = fmc_pkg::CLASS_64;
			end else if (cls_byte == fmc_pkg::ELFCLASS32) begin
				result.elf_class = fmc_pkg::CLASS_32;
			end else begin
				result.elf_class = fmc_pkg::CLASS_UNKNOWN;
			end
			priority if (machine == fmc_pkg::MACHINE_ID_X64) begin
				result.elf_machine = fmc_pkg::MACH_X86_64;
			end else if (machine == fmc_pkg::MACHINE_ID_M68K) begin
				result.elf_machine = fmc_pkg::MACH_M68K;
			end else if (machine != 16'd0) begin
				result.elf_machine = fmc_pkg::MACH_UNKNOWN;
			end else begin
				result.elf_machine = fmc_pkg::MACH_NONE;
			end
		end else if (is_hunk) begin
			result.kind = fmc_pkg::KIND_HUNK;
		end else if (mostly_text) begin
			result.kind = fmc_pkg::KIND_ASCII;
		end else begin
			result.kind = fmc_pkg::KIND_DATA;
		end
	end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the file magic classifier: random byte streams checked against a predictor.
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned ITEM_GOAL = 1350;
	localparam int unsigned CALM_FROM = 1150;
	localparam int unsigned HOLD_FROM = 600;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SHORT_PICK = 77;

	class file_class_tracker;
		int unsigned kept;
		int unsigned text_count;
		fmc_pkg::byte_t header[fmc_pkg::HDR_BYTES];
		fmc_pkg::byte_t machine[2];
		fmc_pkg::result_t pending_classes[$];
		int unsigned errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			kept = 0;
			text_count = 0;
			foreach (header[i]) header[i] = '0;
			machine[0] = '0;
			machine[1] = '0;
		endfunction

		function fmc_pkg::result_t classify_prefix();
			fmc_pkg::result_t r;
			logic [15:0] word;
			logic [15:0] mach_word;
			fmc_pkg::byte_t cls_byte;
			r.kind = fmc_pkg::KIND_DATA;
			r.elf_class = fmc_pkg::CLASS_UNKNOWN;
			r.elf_machine = fmc_pkg::MACH_NONE;
			if (kept < 4) begin
				r.kind = (kept == 0) ? fmc_pkg::KIND_EMPTY : fmc_pkg::KIND_DATA;
			end else if (header[0] == fmc_pkg::WRAP_MAG0 && header[1] == fmc_pkg::WRAP_MAG1 &&
					header[2] == fmc_pkg::WRAP_MAG2 && header[3] == fmc_pkg::WRAP_MAG3) begin
				if (kept >= 6) begin
					word = {header[4], header[5]};
					case (word)
						fmc_pkg::WRAP_TYPE_X64: r.kind = fmc_pkg::KIND_WRAP_X64;
						fmc_pkg::WRAP_TYPE_M68K: r.kind = fmc_pkg::KIND_WRAP_M68K;
						fmc_pkg::WRAP_TYPE_NATIVE: r.kind = fmc_pkg::KIND_WRAP_NATIVE;
						default: r.kind = fmc_pkg::KIND_WRAP_UNKNOWN;
					endcase
				end else begin
					r.kind = fmc_pkg::KIND_WRAP_SHORT;
				end
			end else if (header[0] == fmc_pkg::ELF_MAG0 && header[1] == fmc_pkg::ELF_MAG1 &&
					header[2] == fmc_pkg::ELF_MAG2 && header[3] == fmc_pkg::ELF_MAG3) begin
				r.kind = fmc_pkg::KIND_ELF;
				cls_byte = (kept >= 5) ? header[4] : 8'd0;
				mach_word = '0;
				if ((cls_byte == fmc_pkg::ELFCLASS32 || cls_byte == fmc_pkg::ELFCLASS64) &&
						kept >= fmc_pkg::MACH_MIN_BYTES)
					mach_word = {machine[1], machine[0]};
				if (cls_byte == fmc_pkg::ELFCLASS64)
					r.elf_class = fmc_pkg::CLASS_64;
				else if (cls_byte == fmc_pkg::ELFCLASS32)
					r.elf_class = fmc_pkg::CLASS_32;
				else
					r.elf_class = fmc_pkg::CLASS_UNKNOWN;
				if (mach_word == fmc_pkg::MACHINE_ID_X64)
					r.elf_machine = fmc_pkg::MACH_X86_64;
				else if (mach_word == fmc_pkg::MACHINE_ID_M68K)
					r.elf_machine = fmc_pkg::MACH_M68K;
				else if (mach_word != 16'd0)
					r.elf_machine = fmc_pkg::MACH_UNKNOWN;
				else
					r.elf_machine = fmc_pkg::MACH_NONE;
			end else if ({header[0], header[1], header[2], header[3]} == fmc_pkg::HUNK_MAGIC) begin
				r.kind = fmc_pkg::KIND_HUNK;
			end else if (text_count * fmc_pkg::TEXT_NUM >= kept * fmc_pkg::TEXT_DEN) begin
				r.kind = fmc_pkg::KIND_ASCII;
			end
			return r;
		endfunction

		function void note_item(fmc_pkg::byte_t b, bit present, bit is_last);
			if (present && kept < fmc_pkg::PREFIX_BYTES) begin
				if (kept < fmc_pkg::HDR_BYTES)
					header[kept] = b;
				else if (kept == fmc_pkg::MACH_POS_LO || kept == fmc_pkg::MACH_POS_HI)
					machine[kept - fmc_pkg::MACH_POS_LO] = b;
				if ((b >= 8'h20 && b <= 8'h7E) || (b >= 8'h09 && b <= 8'h0D))
					text_count++;
				kept++;
			end
			if (is_last) begin
				pending_classes.push_back(classify_prefix());
				clear();
			end
		endfunction

		function void check_result(fmc_pkg::result_t got);
			fmc_pkg::result_t want;
			if (pending_classes.size() == 0) begin
				$error("result with no file waiting: kind %0d", got.kind);
				errors++;
				return;
			end
			want = pending_classes.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.elf_class !== want.elf_class) begin
				$error("elf_class: expected %0d, got %0d", want.elf_class, got.elf_class);
				errors++;
			end
			if (got.elf_machine !== want.elf_machine) begin
				$error("elf_machine: expected %0d, got %0d", want.elf_machine, got.elf_machine);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return pending_classes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fmc_byte_if byte_ch ();
	fmc_result_if result_ch ();

	file_magic_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.result_ch(result_ch)
	);

	file_class_tracker tracker = new();

	fmc_pkg::byte_t file_bytes[$];
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	bit noise_on = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready)
				tracker.note_item(byte_ch.data_byte, byte_ch.byte_present, byte_ch.last);
			if (result_ch.valid && result_ch.ready)
				tracker.check_result(fmc_pkg::result_t'({result_ch.kind,
					result_ch.elf_class, result_ch.elf_machine}));
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** file_magic_classifier: FAILED **");
				$finish;
			end
		end
	end

	function automatic fmc_pkg::byte_t text_byte();
		if ($urandom_range(0, 7) == 0)
			return fmc_pkg::byte_t'($urandom_range(9, 13));
		return fmc_pkg::byte_t'($urandom_range(32, 126));
	endfunction

	function automatic fmc_pkg::byte_t binary_byte();
		case ($urandom_range(0, 2))
			0: return fmc_pkg::byte_t'($urandom_range(0, 8));
			1: return fmc_pkg::byte_t'($urandom_range(14, 31));
			default: return fmc_pkg::byte_t'($urandom_range(127, 255));
		endcase
	endfunction

	function void fill_file(input int unsigned pick);
		int unsigned len;
		int unsigned cut;
		int signed odd;
		bit text_body;
		bit is_magic;
		logic [15:0] word;
		file_bytes.delete();
		text_body = $urandom_range(0, 1);
		is_magic = 1'b0;
		if (pick < 15)
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 5) : $urandom_range(6, 30);
		else if (pick < 40)
			case ($urandom_range(0, 5))
				0: len = 4;
				1: len = $urandom_range(5, 19);
				default: len = $urandom_range(20, 40);
			endcase
		else if (pick < 50)
			len = $urandom_range(4, 24);
		else if (pick < 75)
			len = $urandom_range(1, 60);
		else if (pick < 80)
			len = $urandom_range(0, 3);
		else if (pick < 95)
			len = $urandom_range(1, 40);
		else
			len = $urandom_range(fmc_pkg::PREFIX_BYTES + 1, 220);

		for (int i = 0; i < len; i++) begin
			if (pick >= 50 && pick < 75 || pick >= 95 && i < fmc_pkg::PREFIX_BYTES)
				file_bytes.push_back(text_byte());
			else
				file_bytes.push_back(text_body ? text_byte() :
					fmc_pkg::byte_t'($urandom_range(0, 255)));
		end

		if (pick < 15) begin
			is_magic = 1'b1;
			file_bytes[0] = fmc_pkg::WRAP_MAG0;
			file_bytes[1] = fmc_pkg::WRAP_MAG1;
			file_bytes[2] = fmc_pkg::WRAP_MAG2;
			file_bytes[3] = fmc_pkg::WRAP_MAG3;
			if (len >= 6) begin
				case ($urandom_range(0, 4))
					0: word = fmc_pkg::WRAP_TYPE_X64;
					1: word = fmc_pkg::WRAP_TYPE_M68K;
					2: word = fmc_pkg::WRAP_TYPE_NATIVE;
					3: word = 16'h0000;
					default: word = 16'($urandom);
				endcase
				file_bytes[4] = word[15:8];
				file_bytes[5] = word[7:0];
			end
		end else if (pick < 40) begin
			is_magic = 1'b1;
			file_bytes[0] = fmc_pkg::ELF_MAG0;
			file_bytes[1] = fmc_pkg::ELF_MAG1;
			file_bytes[2] = fmc_pkg::ELF_MAG2;
			file_bytes[3] = fmc_pkg::ELF_MAG3;
			if (len >= 5)
				case ($urandom_range(0, 4))
					0, 1: file_bytes[4] = fmc_pkg::ELFCLASS64;
					2: file_bytes[4] = fmc_pkg::ELFCLASS32;
					3: file_bytes[4] = 8'd0;
					default: file_bytes[4] = fmc_pkg::byte_t'($urandom);
				endcase
			if (len >= fmc_pkg::MACH_MIN_BYTES) begin
				case ($urandom_range(0, 5))
					0: word = fmc_pkg::MACHINE_ID_X64;
					1: word = fmc_pkg::MACHINE_ID_M68K;
					2: word = 16'd0;
					3: word = {fmc_pkg::byte_t'($urandom_range(1, 255)),
						fmc_pkg::MACHINE_ID_X64[7:0]};
					4: word = {8'd0, fmc_pkg::byte_t'($urandom)};
					default: word = 16'($urandom);
				endcase
				file_bytes[fmc_pkg::MACH_POS_LO] = word[7:0];
				file_bytes[fmc_pkg::MACH_POS_HI] = word[15:8];
			end
		end else if (pick < 50) begin
			is_magic = 1'b1;
			file_bytes[0] = fmc_pkg::HUNK_MAGIC[31:24];
			file_bytes[1] = fmc_pkg::HUNK_MAGIC[23:16];
			file_bytes[2] = fmc_pkg::HUNK_MAGIC[15:8];
			file_bytes[3] = fmc_pkg::HUNK_MAGIC[7:0];
		end else if (pick < 75) begin
			// push the text share around the ninety percent line
			odd = int'(len / 10) + $urandom_range(0, 2) - 1;
			for (int i = 0; i < odd; i++)
				file_bytes[$urandom_range(0, len - 1)] = binary_byte();
		end else if (pick >= 95) begin
			for (int i = 0; i < $urandom_range(0, 12); i++)
				file_bytes[$urandom_range(0, fmc_pkg::PREFIX_BYTES - 1)] = binary_byte();
			for (int i = fmc_pkg::PREFIX_BYTES; i < len; i++)
				file_bytes[i] = binary_byte();
		end

		if (is_magic) begin
			if ($urandom_range(0, 7) == 0)
				file_bytes[$urandom_range(0, 3)] ^= fmc_pkg::byte_t'(1 << $urandom_range(0, 7));
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, 3);
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end
		end
	endfunction

	task send_item(input fmc_pkg::byte_t b, input bit present, input bit is_last);
		if (sender_idle && $urandom_range(0, 9) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.byte_present <= present;
		byte_ch.last <= is_last;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task send_file();
		int unsigned n;
		bit tail_close;
		n = file_bytes.size();
		tail_close = (n == 0) || ($urandom_range(0, 7) == 0);
		for (int i = 0; i < n; i++) begin
			if (noise_on && $urandom_range(0, 11) == 0)
				send_item(fmc_pkg::byte_t'($urandom), 1'b0, 1'b0);
			send_item(file_bytes[i], 1'b1, !tail_close && i == n - 1);
		end
		if (tail_close)
			send_item(fmc_pkg::byte_t'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.byte_present = 1'b0;
		byte_ch.last = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		file_bytes = {};
		send_file();
		file_bytes = {8'hFF};
		send_file();
		file_bytes = {fmc_pkg::WRAP_MAG0, fmc_pkg::WRAP_MAG1, fmc_pkg::WRAP_MAG2,
			fmc_pkg::WRAP_MAG3, 8'h00, 8'h03};
		send_file();
		file_bytes = {fmc_pkg::WRAP_MAG0, fmc_pkg::WRAP_MAG1, fmc_pkg::WRAP_MAG2,
			fmc_pkg::WRAP_MAG3};
		send_file();
		file_bytes = {fmc_pkg::ELF_MAG0, fmc_pkg::ELF_MAG1, fmc_pkg::ELF_MAG2,
			fmc_pkg::ELF_MAG3};
		send_file();
		file_bytes = {fmc_pkg::HUNK_MAGIC[31:24], fmc_pkg::HUNK_MAGIC[23:16],
			fmc_pkg::HUNK_MAGIC[15:8], fmc_pkg::HUNK_MAGIC[7:0]};
		send_file();
		file_bytes = {8'h09, 8'h0D, 8'h20, 8'h7E};
		send_file();

		noise_on = 1'b1;
		while (items_sent < ITEM_GOAL) begin
			sender_idle = items_sent < CALM_FROM && $urandom_range(0, 3) != 0;
			receiver_idle = items_sent < CALM_FROM && $urandom_range(0, 3) != 0;
			if (!hold_done && items_sent >= HOLD_FROM) begin
				// stall the result side while short files keep coming
				hold_done = 1'b1;
				hold_req = 1'b1;
				repeat (10) begin
					fill_file(SHORT_PICK);
					send_file();
				end
			end
			fill_file($urandom_range(0, 99));
			send_file();
		end
		byte_ch.valid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("** file_magic_classifier: PASSED **");
		else
			$display("** file_magic_classifier: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/fmc_pkg.sv
sv/fmc_byte_if.sv
sv/fmc_result_if.sv
sv/fmc_decide.sv
sv/file_magic_classifier.sv
test/testbench.sv
